/* hdl/iirlp3_pkg.sv */
`default_nettype none

package iirlp3_pkg;

  // Field and number formats
  localparam int SAMPLE_BITS = 12;              // raw converter sample
  localparam int FRAC_BITS   = 28;              // fraction bits of outputs and coefficients
  localparam int SCALE_W     = 32;              // input scale, unsigned Q0.32
  localparam int COEF_W      = 32;              // feedback coefficients, signed
  localparam int Y_W         = 48;              // stored output, signed
  localparam int OUT_W       = 16;              // filtered result
  localparam int HIST_DEPTH  = 3;

  // Derived widths
  localparam int NUM_W  = SAMPLE_BITS + 3;      // x0 + x3 + 3(x1 + x2)
  localparam int XIN_W  = NUM_W + FRAC_BITS;    // scaled numerator
  localparam int YHI_W  = Y_W - FRAC_BITS;      // integer part of an output
  localparam int PHI_W  = COEF_W + YHI_W;       // coef * integer part
  localparam int PLO_W  = COEF_W + FRAC_BITS + 1; // coef * fraction part
  localparam int PLS_W  = PLO_W - FRAC_BITS;    // fraction product after the shift
  localparam int ACC_W  = PHI_W + 3;            // exact sum of all four terms
  localparam int IN_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_MAX = (1 << OUT_W) - 1;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_SCALE = 8'd0,
    REG_FB_OLDEST   = 8'd1,
    REG_FB_MIDDLE   = 8'd2,
    REG_FB_NEWEST   = 8'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [SCALE_W-1:0] INPUT_SCALE_RST = 32'd332185;
  localparam logic [COEF_W-1:0]  FB_OLDEST_RST   = 32'sd216555491;
  localparam logic [COEF_W-1:0]  FB_MIDDLE_RST   = -32'sd696989983;
  localparam logic [COEF_W-1:0]  FB_NEWEST_RST   = 32'sd748703856;

endpackage

`default_nettype wire

/* hdl/iir_lowpass_order3.sv */
// Third-order low-pass IIR filter, one 12-bit sample in, one 16-bit sample out.
// A sample passes the input register, then the result register, on its way to
// out_tvalid. Throughput: one sample per cycle while the output keeps up, set by
// the recursion of the feedback products on the previous outputs within one pass.
// Reset (rst_n low, synchronous): sample and output history cleared to zero,
// configuration registers back to their defaults, both channels empty, no ready.
`default_nettype none

module iir_lowpass_order3 (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input samples
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [iirlp3_pkg::IN_W-1:0]            in_tdata,   // [11:0] sample
  // Filtered samples
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [iirlp3_pkg::OUT_TW-1:0]               out_tdata,  // [15:0] filtered
  // Configuration writes
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [iirlp3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [iirlp3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SB   = iirlp3_pkg::SAMPLE_BITS;
  localparam int FB   = iirlp3_pkg::FRAC_BITS;
  localparam int NW   = iirlp3_pkg::NUM_W;
  localparam int XW   = iirlp3_pkg::XIN_W;
  localparam int CW   = iirlp3_pkg::COEF_W;
  localparam int YW   = iirlp3_pkg::Y_W;
  localparam int YHW  = iirlp3_pkg::YHI_W;
  localparam int PHW  = iirlp3_pkg::PHI_W;
  localparam int PLW  = iirlp3_pkg::PLO_W;
  localparam int PSW  = iirlp3_pkg::PLS_W;
  localparam int AW   = iirlp3_pkg::ACC_W;
  localparam int OW   = iirlp3_pkg::OUT_W;
  localparam int SW   = iirlp3_pkg::SCALE_W;
  localparam int HD   = iirlp3_pkg::HIST_DEPTH;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken whenever out of reset; unknown
  // indexes drop.
  // --------------------------------------------------------------------------
  logic [SW-1:0]        scale_r;
  logic signed [CW-1:0] fb_oldest_r;
  logic signed [CW-1:0] fb_middle_r;
  logic signed [CW-1:0] fb_newest_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= iirlp3_pkg::INPUT_SCALE_RST;
      fb_oldest_r <= iirlp3_pkg::FB_OLDEST_RST;
      fb_middle_r <= iirlp3_pkg::FB_MIDDLE_RST;
      fb_newest_r <= iirlp3_pkg::FB_NEWEST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iirlp3_pkg::REG_INPUT_SCALE: scale_r     <= SW'(cfg_data);
        iirlp3_pkg::REG_FB_OLDEST:   fb_oldest_r <= CW'(cfg_data);
        iirlp3_pkg::REG_FB_MIDDLE:   fb_middle_r <= CW'(cfg_data);
        iirlp3_pkg::REG_FB_NEWEST:   fb_newest_r <= CW'(cfg_data);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. Refill it in the same cycle the held sample moves on, so
  // a transaction can land every cycle while the result side keeps up.
  // --------------------------------------------------------------------------
  logic [SB-1:0] smp_r;
  logic          smp_vld_r;
  logic          fire;        // held sample is filtered into the result register
  logic          out_vld_r;
  logic [OW-1:0] out_data_r;

  assign fire      = smp_vld_r && (!out_vld_r || out_tready);
  assign in_tready = rst_n && (!smp_vld_r || fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_tready) begin
      smp_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r <= in_tdata[SB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // History: index 0 is the oldest. Advance only when a sample is filtered.
  // --------------------------------------------------------------------------
  logic [SB-1:0]        xh_r [HD];
  logic signed [YW-1:0] yh_r [HD];

  // --------------------------------------------------------------------------
  // Filter arithmetic, one pass.
  // Feed-forward: (x[n-3] + x[n] + 3(x[n-2] + x[n-1])) * scale, keep FB
  // fraction bits. Feedback: each c*y is floored to FB fraction bits, done
  // exactly as c*floor(y/2^FB) + floor(c*(y mod 2^FB)/2^FB) so that each
  // multiplier stays at most 32 by 32 bits.
  // --------------------------------------------------------------------------
  logic [NW-1:0]         pair;
  logic [NW-1:0]         num;
  logic [NW+SW-1:0]      num_prod;
  logic [XW-1:0]         xin;
  logic signed [CW-1:0]  coef    [HD];
  logic signed [YHW-1:0] y_int   [HD];
  logic signed [FB:0]    y_frac  [HD];
  logic signed [PHW-1:0] p_hi    [HD];
  logic signed [PLW-1:0] p_lo    [HD];
  logic signed [PSW-1:0] p_lo_sh [HD];
  logic signed [AW-1:0]  acc;
  logic signed [YW-1:0]  y_nxt;
  logic [YHW-1:0]        res_int;
  logic [OW-1:0]         filt_nxt;

  always_comb begin
    pair     = NW'(xh_r[1]) + NW'(xh_r[2]);
    num      = NW'(xh_r[0]) + NW'(smp_r) + pair + (pair << 1);
    num_prod = (NW+SW)'(num) * (NW+SW)'(scale_r);
    xin      = num_prod[NW+SW-1:SW-FB];
  end

  always_comb begin
    coef[0] = fb_oldest_r;
    coef[1] = fb_middle_r;
    coef[2] = fb_newest_r;
    for (int k = 0; k < HD; k++) begin
      y_int[k]   = yh_r[k][YW-1:FB];
      y_frac[k]  = {1'b0, yh_r[k][FB-1:0]};
      p_hi[k]    = coef[k] * y_int[k];
      p_lo[k]    = coef[k] * y_frac[k];
      p_lo_sh[k] = p_lo[k][PLW-1:FB];
    end
  end

  always_comb begin
    acc = $signed({{(AW-XW){1'b0}}, xin});
    for (int k = 0; k < HD; k++) begin
      acc = acc + AW'(p_hi[k]) + AW'(p_lo_sh[k]);
    end
  end

  // Clamp the sum into the stored 48-bit range
  always_comb begin
    if (acc[AW-1:YW-1] == {(AW-YW+1){acc[AW-1]}}) begin
      y_nxt = acc[YW-1:0];
    end else if (acc[AW-1]) begin
      y_nxt = {1'b1, {(YW-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(YW-1){1'b1}}};
    end
  end

  // Result: integer part, negatives to zero, large values to full scale
  always_comb begin
    res_int = y_nxt[YW-1:FB];
    if (y_nxt[YW-1]) begin
      filt_nxt = '0;
    end else if (res_int > YHW'(iirlp3_pkg::OUT_MAX)) begin
      filt_nxt = OW'(iirlp3_pkg::OUT_MAX);
    end else begin
      filt_nxt = res_int[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HD; k++) begin
        xh_r[k] <= '0;
        yh_r[k] <= '0;
      end
    end else if (fire) begin
      for (int k = 0; k < HD-1; k++) begin
        xh_r[k] <= xh_r[k+1];
        yh_r[k] <= yh_r[k+1];
      end
      xh_r[HD-1] <= smp_r;
      yh_r[HD-1] <= y_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. Hold it until the downstream side takes the transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= filt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = iirlp3_pkg::OUT_TW'(out_data_r);

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("filtered sample did not reach the result register");

  a_hist_takes_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> yh_r[HD-1] == $past(y_nxt))
    else $error("output history missed the new output");

  a_held_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
    smp_vld_r && !fire |=> smp_vld_r && $stable(smp_r))
    else $error("held sample lost while the result side stalled");

  a_negative_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && yh_r[HD-1][YW-1] |-> out_data_r == '0)
    else $error("negative output not clamped to zero");
`endif

endmodule

`default_nettype wire

/* tb/tb_iir_lowpass_order3.sv */
`default_nettype none

module tb_iir_lowpass_order3;
  timeunit 1ns;
  timeprecision 1ps;

  // Bench timing and traffic shape
  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 6;
  localparam int IDLE_PCT        = 16;    // chance per cycle that a side idles
  localparam int SETTLE_CYCLES   = 6;     // pipeline is two deep, leave margin
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall to back up the input
  localparam int STALL_LIMIT     = 3000;  // cycles with no transaction at all
  localparam int REPORT_MAX      = 10;
  localparam int RANDOM_SETTINGS = 6;
  localparam int ITEMS_PER_SET   = 75;

  // Widths taken from the package
  localparam int SMP_W   = iirlp3_pkg::SAMPLE_BITS;
  localparam int FRAC_W  = iirlp3_pkg::FRAC_BITS;
  localparam int SCL_W   = iirlp3_pkg::SCALE_W;
  localparam int CF_W    = iirlp3_pkg::COEF_W;
  localparam int YV_W    = iirlp3_pkg::Y_W;
  localparam int RES_W   = iirlp3_pkg::OUT_W;
  localparam int HDEPTH  = iirlp3_pkg::HIST_DEPTH;
  localparam int IDX_W   = iirlp3_pkg::CFG_IDX_W;
  localparam int DAT_W   = iirlp3_pkg::CFG_DATA_W;
  localparam int IWORD_W = iirlp3_pkg::IN_W;
  localparam int OWORD_W = iirlp3_pkg::OUT_TW;

  // Configuration indexes that decode to no register
  localparam logic [IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  // Saturation bounds of the stored output
  localparam logic signed [YV_W-1:0] Y_TOP    = {1'b0, {(YV_W-1){1'b1}}};
  localparam logic signed [YV_W-1:0] Y_BOTTOM = {1'b1, {(YV_W-1){1'b0}}};

  localparam logic [CF_W-1:0] COEF_MAX = {1'b0, {(CF_W-1){1'b1}}};
  localparam logic [CF_W-1:0] COEF_MIN = {1'b1, {(CF_W-1){1'b0}}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IWORD_W-1:0]    in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OWORD_W-1:0]    out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [DAT_W-1:0]      cfg_data  = '0;

  iir_lowpass_order3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Filter state as the bench sees it: configuration mirror plus both histories.
  // Index 0 of every array is the oldest step.
  logic [SCL_W-1:0]       gain_scale = iirlp3_pkg::INPUT_SCALE_RST;
  logic signed [CF_W-1:0] fb_coef [HDEPTH] = '{iirlp3_pkg::FB_OLDEST_RST,
                                              iirlp3_pkg::FB_MIDDLE_RST,
                                              iirlp3_pkg::FB_NEWEST_RST};
  logic [SMP_W-1:0]       x_hist [HDEPTH] = '{default: '0};
  logic signed [YV_W-1:0] y_hist [HDEPTH] = '{default: '0};

  // Filtered samples still owed by the block, oldest first
  logic [RES_W-1:0] filtered_due [$];

  int  error_count     = 0;
  int  stall_cycles    = 0;
  bit  no_gaps         = 1'b0;  // suppress idling on both sides
  int  hold_off_orders = 0;     // bumped by the tests, served by the receiver
  int  hold_off_taken  = 0;
  int  hold_off_left   = 0;

  // Advance the filter by one raw sample and return the filtered value.
  // Each feedback product is floored to FRAC_W fraction bits; the sum is exact
  // and then clamped to the 48-bit output range before it enters the history.
  function automatic logic [RES_W-1:0] filter_step(input logic [SMP_W-1:0] raw);
    logic [63:0]            numer;
    logic [63:0]            scaled;
    logic signed [95:0]     acc;
    logic signed [95:0]     prod;
    logic signed [YV_W-1:0] y_new;
    int k;
    numer  = 64'(x_hist[0]) + 64'(raw) + 64'd3 * (64'(x_hist[1]) + 64'(x_hist[2]));
    scaled = (numer * 64'(gain_scale)) >> (SCL_W - FRAC_W);
    acc    = $signed({32'd0, scaled});
    for (k = 0; k < HDEPTH; k++) begin
      prod = fb_coef[k] * y_hist[k];
      acc  = acc + (prod >>> FRAC_W);
    end
    if (acc > Y_TOP) begin
      y_new = Y_TOP;
    end else if (acc < Y_BOTTOM) begin
      y_new = Y_BOTTOM;
    end else begin
      y_new = acc[YV_W-1:0];
    end
    x_hist[0] = x_hist[1];
    x_hist[1] = x_hist[2];
    x_hist[2] = raw;
    y_hist[0] = y_hist[1];
    y_hist[1] = y_hist[2];
    y_hist[2] = y_new;
    if (y_new < 0) begin
      return '0;
    end else if ((y_new >>> FRAC_W) > iirlp3_pkg::OUT_MAX) begin
      return RES_W'(iirlp3_pkg::OUT_MAX);
    end
    return y_new[FRAC_W +: RES_W];
  endfunction

  // Offer one input word; idle at random first, hold tvalid until the handshake.
  // Pad bits above the sample field go out as given.
  task automatic send_word(input logic [IWORD_W-1:0] word);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filtered_due.push_back(filter_step(word[SMP_W-1:0]));
  endtask

  // Stop sending, wait for every owed result, then let the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration transaction; cfg_valid stays up for a following write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      iirlp3_pkg::REG_INPUT_SCALE: gain_scale = val;
      iirlp3_pkg::REG_FB_OLDEST:   fb_coef[0] = val;
      iirlp3_pkg::REG_FB_MIDDLE:   fb_coef[1] = val;
      iirlp3_pkg::REG_FB_NEWEST:   fb_coef[2] = val;
      default: ;
    endcase
  endtask

  // Load all four registers; call only with the block drained.
  task automatic set_filter(input logic [SCL_W-1:0] scale, input logic [CF_W-1:0] oldest,
                            input logic [CF_W-1:0] middle, input logic [CF_W-1:0] newest);
    write_reg(iirlp3_pkg::REG_INPUT_SCALE, scale);
    write_reg(iirlp3_pkg::REG_FB_OLDEST, oldest);
    write_reg(iirlp3_pkg::REG_FB_MIDDLE, middle);
    write_reg(iirlp3_pkg::REG_FB_NEWEST, newest);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_error(input string msg);
    if (error_count < REPORT_MAX) $display("%s", msg);
    error_count++;
  endtask

  // Reset defaults: full-scale steps up and down (the fall undershoots below
  // zero and must read 0), bit patterns, and words with the pad bits set.
  task automatic test_reset_defaults();
    logic [IWORD_W-1:0] words [$] = '{16'h0000, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF,
                                      16'h0FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                      16'h0AAA, 16'h0555, 16'hF000, 16'hFFFF};
    foreach (words[i]) send_word(words[i]);
    drain();
  endtask

  // Writes to indexes past the last register must leave the filter untouched.
  task automatic test_ignored_index();
    write_reg(REG_UNUSED_LOW, $urandom());
    write_reg(REG_UNUSED_TOP, $urandom());
    cfg_valid <= 1'b0;
    send_word(16'h0800);
    send_word(16'h0001);
    drain();
  endtask

  // Drive the output into both clamps: a large positive loop gain runs into the
  // top of the 48-bit range and the 16-bit ceiling, then the most negative
  // coefficients flip it into the bottom clamp. Finish by flushing the history.
  task automatic test_saturation();
    int i;
    set_filter('1, '0, '0, COEF_MAX);
    for (i = 0; i < 4; i++) send_word(16'h0FFF);
    drain();
    set_filter('0, COEF_MIN, COEF_MIN, COEF_MIN);
    for (i = 0; i < 3; i++) send_word(16'h0FFF);
    drain();
    set_filter('0, '0, '0, '0);
    for (i = 0; i < 3; i++) send_word(16'h0000);
    drain();
  endtask

  // Random content under a series of settings. Samples come in runs: noise, flat
  // plateaus that let the filter settle, full-scale square edges, and one-bit flips.
  task automatic test_random_filtering();
    int set_no;
    int sent;
    int run_len;
    int j;
    int kind;
    logic [SMP_W-1:0] level;
    logic [SMP_W-1:0] raw;
    for (set_no = 0; set_no < RANDOM_SETTINGS; set_no++) begin
      case (set_no)
        0: set_filter($urandom(), iirlp3_pkg::FB_OLDEST_RST, iirlp3_pkg::FB_MIDDLE_RST,
                      iirlp3_pkg::FB_NEWEST_RST);
        1: set_filter(iirlp3_pkg::INPUT_SCALE_RST, iirlp3_pkg::FB_OLDEST_RST,
                      iirlp3_pkg::FB_MIDDLE_RST, iirlp3_pkg::FB_NEWEST_RST);
        2: set_filter($urandom(), CF_W'($signed($urandom_range(2 ** 27)) - 2 ** 26),
                      CF_W'($signed($urandom_range(2 ** 27)) - 2 ** 26),
                      CF_W'($signed($urandom_range(2 ** 27)) - 2 ** 26));
        3: set_filter($urandom(), $urandom(), $urandom(), $urandom());
        4: set_filter('0, $urandom(), $urandom(), $urandom());
        default: set_filter('1, iirlp3_pkg::FB_OLDEST_RST, iirlp3_pkg::FB_MIDDLE_RST,
                            iirlp3_pkg::FB_NEWEST_RST);
      endcase
      // First setting: stall the receiver hard while input keeps coming.
      // Second setting: a long stretch with no idling on either side.
      if (set_no == 0) hold_off_orders++;
      no_gaps = (set_no == 1);
      sent = 0;
      while (sent < ITEMS_PER_SET) begin
        kind    = $urandom_range(3);
        run_len = $urandom_range(12, 1);
        level   = SMP_W'($urandom());
        for (j = 0; j < run_len && sent < ITEMS_PER_SET; j++) begin
          case (kind)
            0: raw = SMP_W'($urandom());
            1: raw = level;
            2: raw = $urandom_range(1) ? '1 : '0;
            default: raw = level ^ (SMP_W'(1) << $urandom_range(SMP_W - 1));
          endcase
          send_word(IWORD_W'(raw));
          sent++;
          // Mid-run pause with the configuration unchanged
          if (set_no == 2 && sent == ITEMS_PER_SET / 2) drain();
        end
      end
      no_gaps = 1'b0;
      drain();
    end
  endtask

  // Receiver: random backpressure, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_tready    <= 1'b0;
    end else if (hold_off_taken != hold_off_orders) begin
      hold_off_taken <= hold_off_taken + 1;
      hold_off_left  <= HOLD_OFF_CYCLES;
      out_tready     <= 1'b0;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted filtered sample against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_due.size() == 0) begin
        report_error($sformatf("unexpected filtered sample %0d", out_tdata[RES_W-1:0]));
      end else if (out_tdata[RES_W-1:0] !== filtered_due[0]) begin
        report_error($sformatf("filtered mismatch: expected %0d, got %0d",
                               filtered_due[0], out_tdata[RES_W-1:0]));
        void'(filtered_due.pop_front());
      end else begin
        void'(filtered_due.pop_front());
      end
    end
  end

  // Watchdog: give up when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("iir_lowpass_order3 verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_ignored_index();
    test_saturation();
    test_random_filtering();
    // drain() already emptied the queue; settle once more to catch strays
    while (filtered_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("iir_lowpass_order3 verification clean");
    end else begin
      $display("iir_lowpass_order3 verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
